// ===== hw/rtl/triangle_triangle_overlap_test_assert.svh =====
// Assertion macros for the triangle overlap block
`ifndef TRIANGLE_TRIANGLE_OVERLAP_TEST_ASSERT_SVH
`define TRIANGLE_TRIANGLE_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication
`define TTO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tto_pkg.sv =====
package tto_pkg;
	localparam int FIELD_BITS     = 48;
	localparam int COORD_BITS_DEF = 16;
	localparam int NSTG           = 6;
	localparam int THR_BITS       = 64;

	typedef struct packed {
		logic [NSTG:1] en;
	} pipe_ctl_t;

	// next index round a triangle
	function automatic int nxt(input int c);
		return (c == 2) ? 0 : c + 1;
	endfunction
endpackage

// ===== hw/rtl/tto_tri_if.sv =====
interface tto_tri_if;
	logic                           valid;
	logic                           ready;
	logic [tto_pkg::FIELD_BITS-1:0] tri_a_vertex0;
	logic [tto_pkg::FIELD_BITS-1:0] tri_a_vertex1;
	logic [tto_pkg::FIELD_BITS-1:0] tri_a_vertex2;
	logic [tto_pkg::FIELD_BITS-1:0] tri_b_vertex0;
	logic [tto_pkg::FIELD_BITS-1:0] tri_b_vertex1;
	logic [tto_pkg::FIELD_BITS-1:0] tri_b_vertex2;

	modport source (output valid, tri_a_vertex0, tri_a_vertex1, tri_a_vertex2,
		tri_b_vertex0, tri_b_vertex1, tri_b_vertex2, input ready);
	modport sink (input valid, tri_a_vertex0, tri_a_vertex1, tri_a_vertex2,
		tri_b_vertex0, tri_b_vertex1, tri_b_vertex2, output ready);
endinterface

// ===== hw/rtl/tto_res_if.sv =====
interface tto_res_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

// ===== hw/rtl/tto_sep.sv =====
module tto_sep #(
	parameter int W = 54
) (
	input  logic signed [W-1:0] pa [3],
	input  logic signed [W-1:0] pb [3],
	output logic                sep
);
	logic signed [W-1:0] amin, amax, bmin, bmax;

	always_comb begin
		amin = pa[0];
		amax = pa[0];
		bmin = pb[0];
		bmax = pb[0];
		for (int k = 1; k < 3; k++) begin
			if (pa[k] < amin) amin = pa[k];
			if (pa[k] > amax) amax = pa[k];
			if (pb[k] < bmin) bmin = pb[k];
			if (pb[k] > bmax) bmax = pb[k];
		end
		sep = (amax < bmin) || (bmax < amin);
	end
endmodule

// ===== hw/rtl/tto_front.sv =====
module tto_front #(
	parameter int COORD_BITS = tto_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  tto_pkg::pipe_ctl_t                   ctl,
	input  logic [tto_pkg::FIELD_BITS-1:0]       vtx [6],
	output logic signed [COORD_BITS:0]           a_s2 [3][3],
	output logic signed [COORD_BITS:0]           b_s2 [3][3],
	output logic signed [COORD_BITS:0]           ea_s2 [3][3],
	output logic signed [COORD_BITS:0]           eb_s2 [3][3],
	output logic signed [2*COORD_BITS+2:0]       na_s2 [3],
	output logic signed [2*COORD_BITS+2:0]       nb_s2 [3],
	output logic signed [2*COORD_BITS+2:0]       ax_s2 [9][3]
);
	import tto_pkg::*;

	localparam int C = COORD_BITS;
	localparam int V = C + 1;
	localparam int N = 2 * C + 3;

	logic signed [C-1:0] raw [6][3];
	logic [63:0]         f64 [6];
	logic signed [V-1:0] a_s1 [3][3], b_s1 [3][3], ea_s1 [3][3], eb_s1 [3][3];
	logic signed [N-1:0] na_d [3], nb_d [3], ax_d [9][3];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			f64[k] = 64'(vtx[k]);
			for (int c = 0; c < 3; c++) raw[k][c] = signed'(f64[k][c*C +: C]);
		end
	end

	// translate to A vertex 0, form edges
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					a_s1[i][c]  <= V'(raw[i][c]) - V'(raw[0][c]);
					b_s1[i][c]  <= V'(raw[3+i][c]) - V'(raw[0][c]);
					ea_s1[i][c] <= V'(raw[nxt(i)][c]) - V'(raw[i][c]);
					eb_s1[i][c] <= V'(raw[3+nxt(i)][c]) - V'(raw[3+i][c]);
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			na_d[c] = N'(ea_s1[0][nxt(c)]) * N'(ea_s1[1][nxt(nxt(c))])
				- N'(ea_s1[0][nxt(nxt(c))]) * N'(ea_s1[1][nxt(c)]);
			nb_d[c] = N'(eb_s1[0][nxt(c)]) * N'(eb_s1[1][nxt(nxt(c))])
				- N'(eb_s1[0][nxt(nxt(c))]) * N'(eb_s1[1][nxt(c)]);
		end
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					ax_d[3*j+i][c] = N'(ea_s1[i][nxt(c)]) * N'(eb_s1[j][nxt(nxt(c))])
						- N'(ea_s1[i][nxt(nxt(c))]) * N'(eb_s1[j][nxt(c)]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			ea_s2 <= ea_s1;
			eb_s2 <= eb_s1;
			na_s2 <= na_d;
			nb_s2 <= nb_d;
			ax_s2 <= ax_d;
		end
	end
endmodule

// ===== hw/rtl/tto_mid.sv =====
module tto_mid #(
	parameter int COORD_BITS = tto_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  tto_pkg::pipe_ctl_t                   ctl,
	input  logic signed [COORD_BITS:0]           a_s2 [3][3],
	input  logic signed [COORD_BITS:0]           b_s2 [3][3],
	input  logic signed [COORD_BITS:0]           ea_s2 [3][3],
	input  logic signed [COORD_BITS:0]           eb_s2 [3][3],
	input  logic signed [2*COORD_BITS+2:0]       na_s2 [3],
	input  logic signed [2*COORD_BITS+2:0]       nb_s2 [3],
	input  logic signed [2*COORD_BITS+2:0]       ax_s2 [9][3],
	output logic                                 face_sep_s4,
	output logic                                 edge_sep_s4,
	output logic                                 big_s4,
	output logic [63:0]                          sq_s4 [3],
	output logic signed [4*COORD_BITS+7:0]       pp_s4 [6][6]
);
	import tto_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int V  = C + 1;
	localparam int N  = 2 * C + 3;
	localparam int P1 = N + V + 2;
	localparam int NN = 2 * N + 1;
	localparam int CN = N + V + 1;
	localparam int P2 = CN + V + 2;

	logic signed [V-1:0]  vt [6][3];
	logic signed [P1-1:0] pfa_d [3], pfb_d [3], pb0_d, pe_d [9][6];
	logic signed [NN-1:0] nn_d [3];
	logic signed [CN-1:0] cn_d [6][3];

	logic signed [P1-1:0] pfa_s3 [3], pfb_s3 [3], pb0_s3, pe_s3 [9][6];
	logic signed [NN-1:0] nn_s3 [3];
	logic signed [CN-1:0] cn_s3 [6][3];
	logic signed [V-1:0]  vt_s3 [6][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vt[k]   = a_s2[k];
			vt[3+k] = b_s2[k];
		end
		for (int k = 0; k < 3; k++) begin
			pfa_d[k] = '0;
			pfb_d[k] = '0;
			for (int c = 0; c < 3; c++) begin
				pfa_d[k] = pfa_d[k] + P1'(na_s2[c]) * P1'(b_s2[k][c]);
				pfb_d[k] = pfb_d[k] + P1'(nb_s2[c]) * P1'(a_s2[k][c]);
			end
		end
		pb0_d = '0;
		for (int c = 0; c < 3; c++) pb0_d = pb0_d + P1'(nb_s2[c]) * P1'(b_s2[0][c]);
		for (int x = 0; x < 9; x++) begin
			for (int k = 0; k < 6; k++) begin
				pe_d[x][k] = '0;
				for (int c = 0; c < 3; c++)
					pe_d[x][k] = pe_d[x][k] + P1'(ax_s2[x][c]) * P1'(vt[k][c]);
			end
		end
		for (int c = 0; c < 3; c++) begin
			nn_d[c] = NN'(na_s2[nxt(c)]) * NN'(nb_s2[nxt(nxt(c))])
				- NN'(na_s2[nxt(nxt(c))]) * NN'(nb_s2[nxt(c)]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) begin
				cn_d[i][c] = CN'(na_s2[nxt(c)]) * CN'(ea_s2[i][nxt(nxt(c))])
					- CN'(na_s2[nxt(nxt(c))]) * CN'(ea_s2[i][nxt(c)]);
				cn_d[3+i][c] = CN'(nb_s2[nxt(c)]) * CN'(eb_s2[i][nxt(nxt(c))])
					- CN'(nb_s2[nxt(nxt(c))]) * CN'(eb_s2[i][nxt(c)]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			pfa_s3 <= pfa_d;
			pfb_s3 <= pfb_d;
			pb0_s3 <= pb0_d;
			pe_s3  <= pe_d;
			nn_s3  <= nn_d;
			cn_s3  <= cn_d;
			vt_s3  <= vt;
		end
	end

	logic signed [P1-1:0] zero3 [3], pb0x3 [3], pea [9][3], peb [9][3];
	logic                 sep_fa, sep_fb;
	logic [8:0]           sep_e;
	logic [NN-1:0]        mag [3];
	logic [2:0]           big_d;
	logic [63:0]          sq_d [3];
	logic signed [P2-1:0] pp_d [6][6];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			zero3[k] = '0;
			pb0x3[k] = pb0_s3;
			for (int x = 0; x < 9; x++) begin
				pea[x][k] = pe_s3[x][k];
				peb[x][k] = pe_s3[x][3+k];
			end
		end
	end

	tto_sep #(.W(P1)) u_sep_fa (.pa(zero3), .pb(pfa_s3), .sep(sep_fa));
	tto_sep #(.W(P1)) u_sep_fb (.pa(pfb_s3), .pb(pb0x3), .sep(sep_fb));

	for (genvar x = 0; x < 9; x++) begin : g_edge
		tto_sep #(.W(P1)) u_sep (.pa(pea[x]), .pb(peb[x]), .sep(sep_e[x]));
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag[c]   = nn_s3[c][NN-1] ? NN'(-nn_s3[c]) : NN'(nn_s3[c]);
			big_d[c] = |mag[c][NN-1:32];
			sq_d[c]  = {32'b0, mag[c][31:0]} * {32'b0, mag[c][31:0]};
		end
		for (int x = 0; x < 6; x++) begin
			for (int k = 0; k < 6; k++) begin
				pp_d[x][k] = '0;
				for (int c = 0; c < 3; c++)
					pp_d[x][k] = pp_d[x][k] + P2'(cn_s3[x][c]) * P2'(vt_s3[k][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			face_sep_s4 <= sep_fa || sep_fb;
			edge_sep_s4 <= |sep_e;
			big_s4      <= |big_d;
			sq_s4       <= sq_d;
			pp_s4       <= pp_d;
		end
	end
endmodule

// ===== hw/rtl/tto_back.sv =====
module tto_back #(
	parameter int COORD_BITS = tto_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  tto_pkg::pipe_ctl_t                   ctl,
	input  logic [tto_pkg::THR_BITS-1:0]         thr,
	input  logic                                 face_sep_s4,
	input  logic                                 edge_sep_s4,
	input  logic                                 big_s4,
	input  logic [63:0]                          sq_s4 [3],
	input  logic signed [4*COORD_BITS+7:0]       pp_s4 [6][6],
	output logic                                 overlap_s6
);
	import tto_pkg::*;

	localparam int P2 = 4 * COORD_BITS + 8;

	logic signed [P2-1:0] ppa [6][3], ppb [6][3];
	logic [5:0]           sep_p;
	logic [65:0]          len2;
	logic                 notpar_d;
	logic                 face_sep_s5, edge_sep_s5, par_sep_s5, notpar_s5;

	always_comb begin
		for (int x = 0; x < 6; x++) begin
			for (int k = 0; k < 3; k++) begin
				ppa[x][k] = pp_s4[x][k];
				ppb[x][k] = pp_s4[x][3+k];
			end
		end
		len2 = 66'(sq_s4[0]) + 66'(sq_s4[1]) + 66'(sq_s4[2]);
		// saturated length beats any threshold but the top code
		if (big_s4 || (len2[65:64] != 2'b00)) notpar_d = (thr != '1);
		else notpar_d = (len2[63:0] > thr);
	end

	for (genvar x = 0; x < 6; x++) begin : g_par
		tto_sep #(.W(P2)) u_sep (.pa(ppa[x]), .pb(ppb[x]), .sep(sep_p[x]));
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			face_sep_s5 <= face_sep_s4;
			edge_sep_s5 <= edge_sep_s4;
			par_sep_s5  <= |sep_p;
			notpar_s5   <= notpar_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			overlap_s6 <= !(face_sep_s5 || (notpar_s5 ? edge_sep_s5 : par_sep_s5));
		end
	end
endmodule

// ===== hw/rtl/triangle_triangle_overlap_test.sv =====
// Separating-axis triangle/triangle overlap test. One triangle pair is
// accepted per cycle unless the pipeline stalls, and its overlap bit
// passes through the six register stages of the exact integer datapath
// (edges, normals and edge axes, projections and normal cross, interval
// checks and squares, parallel decision, result). A stalled output holds
// the pipeline only where stages are full, so bubbles are squeezed out.
// thr_q picks the coplanar path if the squared length of the normals'
// cross product, saturated to 64 bits, does not exceed it; it resets to
// zero. It must be written while no item is in flight (not enforced).
module triangle_triangle_overlap_test #(
	parameter int COORD_BITS = tto_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tto_tri_if.sink                      tri_in,
	tto_res_if.source                    res_out,
	input  logic                         cfg_wr_en,
	input  logic [tto_pkg::THR_BITS-1:0] cfg_wr_data
);
	import tto_pkg::*;

	localparam int C = COORD_BITS;
	localparam int N = 2 * C + 3;

	pipe_ctl_t           ctl;
	logic [NSTG:1]       vld_q;
	logic [THR_BITS-1:0] thr_q;
	logic [FIELD_BITS-1:0] vtx [6];

	logic signed [C:0]       a_s2 [3][3], b_s2 [3][3], ea_s2 [3][3], eb_s2 [3][3];
	logic signed [N-1:0]     na_s2 [3], nb_s2 [3], ax_s2 [9][3];
	logic                    face_sep_s4, edge_sep_s4, big_s4;
	logic [63:0]             sq_s4 [3];
	logic signed [4*C+7:0]   pp_s4 [6][6];

	always_comb begin
		ctl.en[NSTG] = !vld_q[NSTG] || res_out.ready;
		for (int k = NSTG - 1; k >= 1; k--) ctl.en[k] = !vld_q[k] || ctl.en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[1]) vld_q[1] <= tri_in.valid;
			for (int k = 2; k <= NSTG; k++)
				if (ctl.en[k]) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	assign vtx[0] = tri_in.tri_a_vertex0;
	assign vtx[1] = tri_in.tri_a_vertex1;
	assign vtx[2] = tri_in.tri_a_vertex2;
	assign vtx[3] = tri_in.tri_b_vertex0;
	assign vtx[4] = tri_in.tri_b_vertex1;
	assign vtx[5] = tri_in.tri_b_vertex2;

	assign tri_in.ready  = ctl.en[1];
	assign res_out.valid = vld_q[NSTG];

	tto_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .ctl, .vtx, .a_s2, .b_s2, .ea_s2, .eb_s2, .na_s2, .nb_s2, .ax_s2
	);

	tto_mid #(.COORD_BITS(COORD_BITS)) u_mid (
		.clk, .ctl, .a_s2, .b_s2, .ea_s2, .eb_s2, .na_s2, .nb_s2, .ax_s2,
		.face_sep_s4, .edge_sep_s4, .big_s4, .sq_s4, .pp_s4
	);

	tto_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .ctl, .thr(thr_q), .face_sep_s4, .edge_sep_s4, .big_s4, .sq_s4,
		.pp_s4, .overlap_s6(res_out.overlap)
	);
endmodule

// ===== hw/rtl/tto_chk.sv =====
`include "triangle_triangle_overlap_test_assert.svh"

module tto_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic overlap
);
	`TTO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped")
	`TTO_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(overlap), "result item changed")
	`TTO_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input held with empty output")
	`TTO_ASSERT_NOW(a_flow_ready, out_ready, in_ready, "input held while output drains")
endmodule

bind triangle_triangle_overlap_test tto_chk u_tto_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(tri_in.ready),
	.out_valid(res_out.valid),
	.out_ready(res_out.ready),
	.overlap(res_out.overlap)
);
